// ===== src/itit_pkg.sv =====
// Shared types, constants and tables for the ISO tier image tuning block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package itit_pkg;

  // Control word geometry
  localparam int CTRL_N = 5;
  localparam int CTRL_W = 7;
  localparam int TIER_W = 2;
  localparam int TIER_N = 4;
  localparam int ISO_W  = 32;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CTRL_W-1:0] CTRL_MAX = 7'd100;

  // Control lane order
  localparam int CTRL_SAT      = 0;
  localparam int CTRL_SHARP    = 1;
  localparam int CTRL_SPATIAL  = 2;
  localparam int CTRL_TEMPORAL = 3;
  localparam int CTRL_GAMMA    = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SAT      = 3'd0,
    CFG_BASE_SHARP    = 3'd1,
    CFG_BASE_SPATIAL  = 3'd2,
    CFG_BASE_TEMPORAL = 3'd3,
    CFG_BASE_GAMMA    = 3'd4,
    CFG_MODE          = 3'd5
  } cfg_idx_t;

  // Tuning modes; the fourth code falls back to the normal table
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUIET  = 2'd1,
    MODE_DETAIL = 2'd2
  } mode_t;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_QUIET;

  // ISO tier upper limits (inclusive)
  localparam logic [ISO_W-1:0] ISO_LIM0 = 32'd400;
  localparam logic [ISO_W-1:0] ISO_LIM1 = 32'd1600;
  localparam logic [ISO_W-1:0] ISO_LIM2 = 32'd6400;

  // Base control reset values
  localparam logic [CTRL_W-1:0] BASE_RST [CTRL_N] = '{7'd52, 7'd32, 7'd60, 7'd52, 7'd50};

  // Per mode, per control, per tier signed deltas
  localparam logic signed [7:0] DELTA_TAB [3][CTRL_N][TIER_N] = '{
    '{ // normal
      '{ 8'sd0,  8'sd0, -8'sd6,  -8'sd14},
      '{ 8'sd0, -8'sd6, -8'sd14, -8'sd24},
      '{ 8'sd0,  8'sd8,  8'sd18,  8'sd30},
      '{ 8'sd0,  8'sd10, 8'sd22,  8'sd34},
      '{ 8'sd0,  8'sd2,  8'sd5,   8'sd8}
    },
    '{ // low noise
      '{ 8'sd0, -8'sd2, -8'sd6,  -8'sd12},
      '{-8'sd2, -8'sd4, -8'sd10, -8'sd16},
      '{ 8'sd4,  8'sd10, 8'sd18,  8'sd26},
      '{ 8'sd4,  8'sd12, 8'sd26,  8'sd36},
      '{ 8'sd0,  8'sd1,  8'sd4,   8'sd7}
    },
    '{ // detail
      '{ 8'sd5,  8'sd2, -8'sd4,  -8'sd10},
      '{ 8'sd8,  8'sd2, -8'sd8,  -8'sd18},
      '{-8'sd6,  8'sd2,  8'sd12,  8'sd24},
      '{-8'sd4,  8'sd4,  8'sd16,  8'sd28},
      '{ 8'sd0,  8'sd3,  8'sd7,   8'sd10}
    }
  };

  // Low noise cap on the 3D denoise control, per tier
  localparam logic [CTRL_W-1:0] LN_CAP [TIER_N] = '{7'd56, 7'd66, 7'd84, 7'd88};

  // Divide by 3 for magnitudes up to 100: (m * 43) >> 7
  localparam int                DIV3_MUL_W = 6;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 6'd43;
  localparam int                DIV3_SHIFT = 7;

  // Queue depth between stages
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One work item: targets on the way in, smoothed controls on the way out
  typedef struct packed {
    logic                           cap_en;
    logic [TIER_W-1:0]              tier;
    logic [CTRL_N-1:0][CTRL_W-1:0]  ctrl;
  } work_t;

endpackage

`default_nettype wire

// ===== src/itit_queue.sv =====
// Short FIFO of work items between stages of the ISO tier tuning block.
// Depends on itit_pkg (work_t, QDEPTH).
`default_nettype none

module itit_queue
  import itit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t din,
  output logic       full,
  input  wire logic  pop,
  output work_t      dout,
  output logic       empty
);

  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  work_t             mem_r [QDEPTH];
  logic              push_ok, pop_ok;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> !empty)
    else $error("queue empty after a transfer in");

endmodule

`default_nettype wire

// ===== src/itit_front.sv =====
// Front stage: configuration registers, ISO tier classification and target
// computation (delta, clamp, low noise cap). Depends on itit_pkg.
`default_nettype none

module itit_front
  import itit_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [ISO_W-1:0]      in_iso,
  output logic                       q_push,
  output work_t                      q_item,
  input  wire logic                  q_full
);

  logic [CTRL_N-1:0][CTRL_W-1:0] base_r, base_nxt;
  logic [MODE_W-1:0]             mode_r, mode_nxt;
  logic                          valid_r, valid_nxt;
  work_t                         stg_r;
  work_t                         work;
  logic                          accept;
  logic [TIER_W-1:0]             tier;
  logic [1:0]                    tab;
  logic signed [8:0]             sum [CTRL_N];

  assign cfg_ready = 1'b1;

  // configuration write decode; unknown indexes are dropped
  always_comb begin
    base_nxt = base_r;
    mode_nxt = mode_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE_SAT:      base_nxt[CTRL_SAT]      = cfg_data;
        CFG_BASE_SHARP:    base_nxt[CTRL_SHARP]    = cfg_data;
        CFG_BASE_SPATIAL:  base_nxt[CTRL_SPATIAL]  = cfg_data;
        CFG_BASE_TEMPORAL: base_nxt[CTRL_TEMPORAL] = cfg_data;
        CFG_BASE_GAMMA:    base_nxt[CTRL_GAMMA]    = cfg_data;
        CFG_MODE:          mode_nxt                = cfg_data[MODE_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTRL_N; i++) begin
        base_r[i] <= BASE_RST[i];
      end
      mode_r <= MODE_RST;
    end else begin
      base_r <= base_nxt;
      mode_r <= mode_nxt;
    end
  end

  // tier classification
  always_comb begin
    priority if (in_iso <= ISO_LIM0) begin
      tier = 2'd0;
    end else if (in_iso <= ISO_LIM1) begin
      tier = 2'd1;
    end else if (in_iso <= ISO_LIM2) begin
      tier = 2'd2;
    end else begin
      tier = 2'd3;
    end
  end

  // unused mode code takes the normal table
  assign tab = (mode_r > MODE_DETAIL) ? MODE_NORMAL : mode_r;

  // targets: base + delta, clamped to 0..100, then the 3D denoise cap in low noise mode
  always_comb begin
    work.cap_en = (mode_r == MODE_QUIET);
    work.tier   = tier;
    for (int i = 0; i < CTRL_N; i++) begin
      sum[i] = $signed({2'b00, base_r[i]}) + $signed({DELTA_TAB[tab][i][tier][7],
                                                       DELTA_TAB[tab][i][tier]});
      if (sum[i][8]) begin
        work.ctrl[i] = '0;
      end else if (sum[i] > $signed({2'b00, CTRL_MAX})) begin
        work.ctrl[i] = CTRL_MAX;
      end else begin
        work.ctrl[i] = sum[i][CTRL_W-1:0];
      end
    end
    if (work.cap_en && (work.ctrl[CTRL_TEMPORAL] > LN_CAP[tier])) begin
      work.ctrl[CTRL_TEMPORAL] = LN_CAP[tier];
    end
  end

  // stage register toward the queue
  assign in_full   = valid_r && q_full;
  assign accept    = in_push && !in_full;
  assign q_push    = valid_r;
  assign q_item    = stg_r;
  assign valid_nxt = accept ? 1'b1 : (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= work;
    end
  end

endmodule

`default_nettype wire

// ===== src/itit_back.sv =====
// Back stage: smoothing of the targets against the held controls, low noise
// cap reapplied, held state update. Depends on itit_pkg.
`default_nettype none

module itit_back
  import itit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire work_t q_item,
  output logic       q_pop,
  input  wire logic  o_full,
  output logic       o_push,
  output work_t      o_item
);

  localparam int PROD_W = CTRL_W + DIV3_MUL_W;

  logic                          active_r, active_nxt;
  logic [CTRL_N-1:0][CTRL_W-1:0] held_r, held_nxt;
  logic [CTRL_N-1:0][CTRL_W-1:0] pick;
  logic signed [CTRL_W:0]        diff [CTRL_N];
  logic [CTRL_W-1:0]             mag  [CTRL_N];
  logic [PROD_W-1:0]             prod [CTRL_N];
  logic [CTRL_W-1:0]             step [CTRL_N];
  logic [CTRL_W-1:0]             sm   [CTRL_N];
  logic                          fire;

  assign fire  = !q_empty && !o_full;
  assign q_pop = fire;

  // per lane: held + (target - held) / 3, truncating toward zero
  for (genvar g = 0; g < CTRL_N; g++) begin : g_lane
    assign diff[g] = $signed({1'b0, q_item.ctrl[g]}) - $signed({1'b0, held_r[g]});
    assign mag[g]  = diff[g][CTRL_W] ? CTRL_W'(-diff[g]) : diff[g][CTRL_W-1:0];
    assign prod[g] = PROD_W'(mag[g]) * PROD_W'(DIV3_MUL);
    assign step[g] = CTRL_W'(prod[g] >> DIV3_SHIFT);
    assign sm[g]   = diff[g][CTRL_W] ? held_r[g] - step[g] : held_r[g] + step[g];
    assign pick[g] = active_r ? sm[g] : q_item.ctrl[g];
  end

  // cap reapplied after smoothing
  always_comb begin
    held_nxt   = held_r;
    active_nxt = active_r;
    if (fire) begin
      held_nxt   = pick;
      active_nxt = 1'b1;
      if (q_item.cap_en && (pick[CTRL_TEMPORAL] > LN_CAP[q_item.tier])) begin
        held_nxt[CTRL_TEMPORAL] = LN_CAP[q_item.tier];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      held_r   <= '0;
    end else begin
      active_r <= active_nxt;
      held_r   <= held_nxt;
    end
  end

  // result toward the output queue
  assign o_push        = fire;
  assign o_item.cap_en = 1'b0;
  assign o_item.tier   = q_item.tier;
  assign o_item.ctrl   = held_nxt;

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r[0] <= CTRL_MAX) && (held_r[1] <= CTRL_MAX) && (held_r[2] <= CTRL_MAX) &&
    (held_r[3] <= CTRL_MAX) && (held_r[4] <= CTRL_MAX))
    else $error("held control above 100");

  a_cap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && q_item.cap_en) |=> (held_r[CTRL_TEMPORAL] <= LN_CAP[$past(q_item.tier)]))
    else $error("3D denoise above low noise cap");

  a_active_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> active_r)
    else $error("smoothing not active after a transfer");

endmodule

`default_nettype wire

// ===== src/iso_tier_image_tuning.sv =====
// ISO tier image tuning, top level. An input transfer loads the front stage
// register; from there the item moves into the mid queue and, through the back
// stage, into the output queue, where the result shows.
// Throughput: one item per cycle while no queue is full; the held-control update
// in the back stage completes with each transfer, so items follow back to back.
// Reset: synchronous active low; base controls and mode return to defaults,
// held controls clear to 0 and the first item after reset is not smoothed.
`default_nettype none

module iso_tier_image_tuning
  import itit_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [ISO_W-1:0]      in_iso,
  input  wire logic                  out_pop,
  output logic                       out_empty,
  output logic [CTRL_W-1:0]          out_saturation_out,
  output logic [CTRL_W-1:0]          out_sharpness_out,
  output logic [CTRL_W-1:0]          out_denoise_spatial_out,
  output logic [CTRL_W-1:0]          out_denoise_temporal_out,
  output logic [CTRL_W-1:0]          out_gamma_out,
  output logic [TIER_W-1:0]          out_tier_out
);

  logic  mq_push, mq_full, mq_pop, mq_empty;
  work_t mq_din, mq_dout;
  logic  oq_push, oq_full;
  work_t oq_din, oq_dout;

  itit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_iso    (in_iso),
    .q_push    (mq_push),
    .q_item    (mq_din),
    .q_full    (mq_full)
  );

  itit_queue u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  itit_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mq_empty),
    .q_item  (mq_dout),
    .q_pop   (mq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_item  (oq_din)
  );

  itit_queue u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_dout),
    .empty (out_empty)
  );

  // result fields
  assign out_saturation_out       = oq_dout.ctrl[CTRL_SAT];
  assign out_sharpness_out        = oq_dout.ctrl[CTRL_SHARP];
  assign out_denoise_spatial_out  = oq_dout.ctrl[CTRL_SPATIAL];
  assign out_denoise_temporal_out = oq_dout.ctrl[CTRL_TEMPORAL];
  assign out_gamma_out            = oq_dout.ctrl[CTRL_GAMMA];
  assign out_tier_out             = oq_dout.tier;

endmodule

`default_nettype wire
